/* src/frs_pkg.sv */
// Types and constants shared by the FAT32 file read sequencer modules.
`default_nettype none

package frs_pkg;

    localparam logic [9:0]  SECTOR_BYTES       = 10'd512;
    localparam logic [27:0] ENTRY_BAD          = 28'hFFFFFF7;
    localparam logic [27:0] ENTRY_EOC          = 28'hFFFFFF8;
    localparam int          FAT_SLOT_BITS      = 7;
    localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;
    localparam logic [7:0]  MAX_CHUNK          = 8'd128;
    localparam logic [7:0]  CHUNK_RESET        = 8'd64;

    localparam logic [1:0] MODE_OPEN  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_REPLY = 2'd2;

    localparam logic [1:0] REG_FAT_START  = 2'd0;
    localparam logic [1:0] REG_DATA_START = 2'd1;
    localparam logic [1:0] REG_CLUS_SHIFT = 2'd2;
    localparam logic [1:0] REG_CHUNK_SIZE = 2'd3;

    typedef enum logic [2:0] {
        ST_CHUNK      = 3'd0,
        ST_EOF        = 3'd1,
        ST_BAD        = 3'd2,
        ST_NEED_FAT   = 3'd3,
        ST_OPENED     = 3'd4,
        ST_UNEXPECTED = 3'd5
    } status_e_t;

    typedef struct packed {
        logic [31:0] fat_start_sector;
        logic [31:0] data_start_sector;
        logic [2:0]  cluster_shift;
        logic [7:0]  chunk_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [27:0] start_cluster;
        logic [31:0] file_length;
        logic [31:0] fat_entry;
    } in_item_t;

    typedef struct packed {
        status_e_t   status;
        logic [31:0] data_lba;
        logic        load_data_lba;
        logic [31:0] fat_sector_addr;
        logic        load_fat_sector;
        logic [6:0]  fat_slot;
        logic [8:0]  buffer_offset;
        logic [7:0]  byte_count;
        logic [31:0] bytes_left;
    } result_t;

    typedef struct packed {
        logic [27:0] current_cluster;
        logic [31:0] current_sector;
        logic [9:0]  offset_in_sector;
        logic [7:0]  sector_in_cluster;
        logic [31:0] remaining_bytes;
        logic [31:0] cached_fat_sector;
        logic        awaiting_entry;
        logic        error_latched;
    } state_t;

endpackage

`default_nettype wire

/* src/frs_cfg.sv */
// Configuration register file of the FAT32 file read sequencer.
`default_nettype none

module frs_cfg import frs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FAT_START:  cfg_next.fat_start_sector  = cfg_data;
                REG_DATA_START: cfg_next.data_start_sector = cfg_data;
                REG_CLUS_SHIFT: cfg_next.cluster_shift     = cfg_data[2:0];
                REG_CHUNK_SIZE: cfg_next.chunk_size        = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fat_start_sector  <= '0;
            cfg_reg.data_start_sector <= '0;
            cfg_reg.cluster_shift     <= '0;
            cfg_reg.chunk_size        <= CHUNK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* src/frs_engine.sv */
// File position state and the combinational step logic of the read sequencer.
`default_nettype none

module frs_engine import frs_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output result_t   res
);

    state_t      st_reg, st_next;
    logic [7:0]  lim;
    logic [27:0] entry;
    logic [27:0] base_cluster;
    logic [31:0] base_sector;
    logic [31:0] cur_fat_addr;
    logic        sector_end;
    logic [7:0]  sic_inc;
    logic        cluster_end;
    logic [9:0]  chunk_off;
    logic [9:0]  room;
    logic [7:0]  n_lim;
    logic [7:0]  n;
    logic        take;

    always_comb begin
        lim          = (cfg.chunk_size > MAX_CHUNK) ? MAX_CHUNK : cfg.chunk_size;
        entry        = item.fat_entry[27:0];
        base_cluster = (item.mode == MODE_OPEN) ? item.start_cluster : entry;
        base_sector  = (({4'd0, base_cluster} - FIRST_DATA_CLUSTER) << cfg.cluster_shift)
                       + cfg.data_start_sector;
        cur_fat_addr = cfg.fat_start_sector
                       + {11'd0, st_reg.current_cluster[27:FAT_SLOT_BITS]};
        sector_end   = st_reg.offset_in_sector >= SECTOR_BYTES;
        sic_inc      = st_reg.sector_in_cluster + 8'd1;
        cluster_end  = sector_end && (sic_inc == (8'd1 << cfg.cluster_shift));
        chunk_off    = (item.mode == MODE_READ && !sector_end) ? st_reg.offset_in_sector
                                                                 : 10'd0;
        room         = SECTOR_BYTES - chunk_off;
        n_lim        = (st_reg.remaining_bytes < {24'd0, lim})
                       ? st_reg.remaining_bytes[7:0] : lim;
        n            = ({2'd0, n_lim} > room) ? room[7:0] : n_lim;
    end

    always_comb begin
        st_next = st_reg;
        take    = 1'b0;
        res     = '0;
        res.status = ST_UNEXPECTED;
        case (item.mode)
            MODE_OPEN: begin
                st_next.current_cluster   = item.start_cluster;
                st_next.remaining_bytes   = item.file_length;
                st_next.offset_in_sector  = '0;
                st_next.sector_in_cluster = '0;
                st_next.current_sector    = base_sector;
                st_next.awaiting_entry    = 1'b0;
                st_next.error_latched     = 1'b0;
                res.status                = ST_OPENED;
                res.load_data_lba         = 1'b1;
            end
            MODE_READ: begin
                if (st_reg.error_latched) begin
                    res.status = ST_BAD;
                end else if (st_reg.awaiting_entry) begin
                    res.load_fat_sector       = cur_fat_addr != st_reg.cached_fat_sector;
                    st_next.cached_fat_sector = cur_fat_addr;
                    res.status                = ST_NEED_FAT;
                end else if (st_reg.remaining_bytes == 32'd0) begin
                    res.status = ST_EOF;
                end else if (cluster_end) begin
                    st_next.sector_in_cluster = sic_inc;
                    res.load_fat_sector       = cur_fat_addr != st_reg.cached_fat_sector;
                    st_next.cached_fat_sector = cur_fat_addr;
                    st_next.awaiting_entry    = 1'b1;
                    res.status                = ST_NEED_FAT;
                end else begin
                    if (sector_end) begin
                        st_next.sector_in_cluster = sic_inc;
                        st_next.current_sector    = st_reg.current_sector + 32'd1;
                        res.load_data_lba         = 1'b1;
                    end
                    take       = 1'b1;
                    res.status = ST_CHUNK;
                end
            end
            MODE_REPLY: begin
                if (st_reg.awaiting_entry) begin
                    st_next.awaiting_entry = 1'b0;
                    if (entry == ENTRY_BAD) begin
                        st_next.error_latched = 1'b1;
                        res.status            = ST_BAD;
                    end else if (entry >= ENTRY_EOC) begin
                        st_next.remaining_bytes = '0;
                        res.status              = ST_EOF;
                    end else begin
                        st_next.current_cluster   = entry;
                        st_next.current_sector    = base_sector;
                        st_next.sector_in_cluster = '0;
                        res.load_data_lba         = 1'b1;
                        take                      = 1'b1;
                        res.status                = ST_CHUNK;
                    end
                end
            end
            default: res.status = ST_UNEXPECTED;
        endcase
        if (take) begin
            st_next.remaining_bytes  = st_reg.remaining_bytes - {24'd0, n};
            st_next.offset_in_sector = chunk_off + {2'd0, n};
            res.buffer_offset        = chunk_off[8:0];
            res.byte_count           = n;
        end
        res.data_lba        = st_next.current_sector;
        res.fat_sector_addr = cfg.fat_start_sector
                              + {11'd0, st_next.current_cluster[27:FAT_SLOT_BITS]};
        res.fat_slot        = st_next.current_cluster[FAT_SLOT_BITS-1:0];
        res.bytes_left      = st_next.remaining_bytes;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

/* src/fat32_file_read_sequencer.sv */
// Top level of the FAT32 file read sequencer with input and result registers.
`default_nettype none

// An accepted item is held in the input register and stepped from there, and
// its result is captured in the result register and presented from it; a new
// item is accepted in every cycle while the result side keeps taking results.
// The block holds the position in one open file: an open item sets the first
// cluster and the size, each read item returns the next chunk of the sector
// buffer, and at the end of a cluster it asks for a FAT entry, which the host
// returns with a reply item. Configuration writes are taken at any time but
// are meant to happen while the block holds no item.

module fat32_file_read_sequencer import frs_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // start_cluster[27:0], file_length[59:28], fat_entry[91:60], zero fill.
    input  wire logic [95:0]  s_tdata,
    // mode[1:0].
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // data_lba[31:0], load_data_lba[32], fat_sector_addr[64:33],
    // load_fat_sector[65], fat_slot[72:66], buffer_offset[81:73],
    // byte_count[89:82], bytes_left[121:90], zero fill.
    output logic [127:0]      m_tdata,
    // status[2:0].
    output logic [2:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    cfg_t     cfg;
    in_item_t in_reg, in_next;
    logic     in_valid_reg, in_valid_next;
    result_t  res;
    result_t  out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    logic     s_accept;
    logic     advance;

    frs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_next.mode          = s_tuser;
        in_next.start_cluster = s_tdata[27:0];
        in_next.file_length   = s_tdata[59:28];
        in_next.fat_entry     = s_tdata[91:60];
        in_valid_next         = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_next              = advance ? res : out_reg;
        out_valid_next        = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= in_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0,
                       out_reg.bytes_left,
                       out_reg.byte_count,
                       out_reg.buffer_offset,
                       out_reg.fat_slot,
                       out_reg.load_fat_sector,
                       out_reg.fat_sector_addr,
                       out_reg.load_data_lba,
                       out_reg.data_lba};

`ifndef ASSERT_OFF
    a_load_fat_only_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.load_fat_sector) |-> (out_reg.status == ST_NEED_FAT))
        else $error("FAT sector load flagged without a FAT entry request");

    a_bytes_only_in_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.byte_count != 8'd0) |->
            (out_reg.status == ST_CHUNK && out_reg.byte_count <= MAX_CHUNK))
        else $error("Byte count out of range or outside a chunk result");

    a_result_follows_item: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("Processed item did not produce a result");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("Input register lost a stalled item");
`endif

endmodule

`default_nettype wire
